### rtl/core/qse_pkg.sv
// Shared constants for the quicksort engine.
// No dependencies; used by the top level and the element RAM.
`timescale 1ns / 1ps

package qse_pkg;

	// Width of one element beat on both channels.
	localparam int DATA_W = 32;

	// Default number of elements the store can hold.
	localparam int DEPTH_DEF = 64;

endpackage

### rtl/core/quicksort_engine_unit.sv
// Top level of the quicksort engine: load, in-place sort and ordered read-out.
// Depends on qse_pkg and on qse_ram for the element store.
`timescale 1ns / 1ps

// How to use this block:
// Elements arrive as beats on the item channel (item_valid, item_stall, value, last).
// Each accepted beat is written into the element store; beats that arrive
// once DEPTH elements are held are dropped. The beat marked last starts the sort,
// whether or not it could be stored. While sorting and reading out, item_stall is high.
// The sort is an in-place quicksort driven by a small sequencer around one comparator
// and the single read port of the store. Each partition passes through S_RANGE and
// S_PIV for setup, one S_CMP pointer step per element visited, and S_FIN to wrap up;
// the one RAM read port sets the pace of the pointer steps.
// Read-out then sends the stored elements in ascending order on the result channel
// (res_valid, res_stall, sorted_value, final_res), one beat per cycle while res_stall
// is low, after the S_EADDR start step, with final_res set on the last one. A stalled
// result is held in the output register and read-out pauses until it is taken. When
// the last result has been loaded into the output register the store is empty and a
// new set may be loaded while that result still waits.
// Reset (arst_n low) empties the store and drops any sort or read-out under way;
// result data comes out only for sets loaded after reset.

module quicksort_engine_unit #(
	parameter int DEPTH = qse_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic signed [qse_pkg::DATA_W-1:0] value,
	input  logic                              last,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic signed [qse_pkg::DATA_W-1:0] sorted_value,
	output logic                              final_res
);

	localparam int DW  = qse_pkg::DATA_W;
	localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // element address
	localparam int CW  = $clog2(DEPTH + 1);                 // element count
	localparam int IW  = AW + 2;                            // signed range bound
	// Only ranges of two or more elements are stacked, and the larger half is the
	// one stacked, so the stack never holds more than log2(DEPTH) ranges.
	localparam int SD  = AW;
	localparam int SPW = $clog2(SD + 1);
	localparam int SIW = (SD > 1) ? $clog2(SD) : 1;

	typedef struct packed {
		logic signed [IW-1:0] lo;
		logic signed [IW-1:0] hi;
	} range_t;

	typedef enum logic [2:0] {
		S_LOAD,    // taking element beats
		S_RANGE,   // choose the next range to partition, or finish
		S_PIV,     // capture the pivot, fetch the right end
		S_CMP,     // one pointer step per cycle
		S_FIN,     // drop the pivot in place, split the range
		S_EADDR,   // start read-out
		S_EDATA    // stream sorted elements
	} state_t;

	state_t state_q;

	logic [CW-1:0]        count_q;
	logic signed [IW-1:0] lo_q;
	logic signed [IW-1:0] hi_q;
	logic [AW-1:0]        l_q;
	logic [AW-1:0]        r_q;
	logic                 rmv_q;      // 1 while the right pointer moves
	logic signed [DW-1:0] pv_q;       // pivot value, kept out of the store
	range_t               stack_q [SD];
	logic [SPW-1:0]       sp_q;
	logic [AW-1:0]        k_q;

	logic                 res_valid_q;
	logic signed [DW-1:0] sorted_value_q;
	logic                 final_res_q;

	// Store ports.
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [DW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [DW-1:0] ram_rdata;

	qse_ram #(
		.WIDTH (DW),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Load path.
	logic          has_room;
	logic [CW-1:0] count_nx;

	assign has_room = (count_q < CW'(DEPTH));
	assign count_nx = has_room ? (count_q + CW'(1)) : count_q;

	// Pointer step: the shared comparator tests the element under the moving
	// pointer against the pivot. A stop on an equal key still swaps and steps,
	// so every partition finishes.
	logic signed [DW-1:0] x;
	logic                 go_on;
	logic                 stop;
	logic [AW-1:0]        l_nx;
	logic [AW-1:0]        r_nx;
	logic                 rmv_nx;

	assign x     = $signed(ram_rdata);
	assign go_on = rmv_q ? (pv_q < x) : (x < pv_q);
	assign stop  = !go_on;

	always_comb begin
		l_nx   = l_q;
		r_nx   = r_q;
		rmv_nx = rmv_q;
		if (rmv_q) begin
			if (go_on) begin
				r_nx = r_q - AW'(1);
			end else begin
				l_nx   = l_q + AW'(1);
				rmv_nx = 1'b0;
			end
		end else begin
			if (go_on) begin
				l_nx = l_q + AW'(1);
			end else begin
				r_nx   = r_q - AW'(1);
				rmv_nx = 1'b1;
			end
		end
	end

	// Split after a partition: the pivot lands where the pointers met.
	logic signed [IW-1:0] p;
	logic signed [IW-1:0] p_m1;
	logic signed [IW-1:0] p_p1;
	logic signed [IW-1:0] lsz;
	logic signed [IW-1:0] rsz;

	assign p    = $signed(IW'(l_q));
	assign p_m1 = p - IW'(1);
	assign p_p1 = p + IW'(1);
	assign lsz  = p_m1 - lo_q;
	assign rsz  = hi_q - p_p1;

	// Read-out.
	logic out_free;
	logic is_final;
	logic res_load;

	assign out_free = !res_valid_q || !res_stall;
	assign is_final = ((CW'(k_q) + CW'(1)) == count_q);
	assign res_load = (state_q == S_EDATA) && out_free;

	logic [SPW-1:0] sp_m1;
	assign sp_m1 = sp_q - SPW'(1);

	// Store port control.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = value;
		ram_re    = 1'b0;
		ram_raddr = k_q;
		case (state_q)
			S_LOAD: begin
				ram_we = item_valid && has_room;
			end
			S_RANGE: begin
				ram_re    = (hi_q > lo_q);
				ram_raddr = lo_q[AW-1:0];
			end
			S_PIV: begin
				ram_re    = 1'b1;
				ram_raddr = r_q;
			end
			S_CMP: begin
				ram_we    = stop;
				ram_waddr = rmv_q ? l_q : r_q;
				ram_wdata = ram_rdata;
				ram_re    = (l_nx < r_nx);
				ram_raddr = rmv_nx ? r_nx : l_nx;
			end
			S_FIN: begin
				ram_we    = 1'b1;
				ram_waddr = l_q;
				ram_wdata = pv_q;
			end
			S_EADDR: begin
				ram_re = 1'b1;
			end
			S_EDATA: begin
				ram_re    = out_free && !is_final;
				ram_raddr = k_q + AW'(1);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_LOAD;
			count_q        <= '0;
			sp_q           <= '0;
			rmv_q          <= 1'b1;
			l_q            <= '0;
			r_q            <= '0;
			lo_q           <= '0;
			hi_q           <= '0;
			pv_q           <= '0;
			k_q            <= '0;
			for (int i = 0; i < SD; i++) begin
				stack_q[i] <= '0;
			end
			res_valid_q    <= 1'b0;
			sorted_value_q <= '0;
			final_res_q    <= 1'b0;
		end else begin
			// The output register loads a new beat or empties once its beat is taken.
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (item_valid) begin
						count_q <= count_nx;
						if (last) begin
							lo_q    <= '0;
							hi_q    <= $signed(IW'(count_nx)) - IW'(1);
							sp_q    <= '0;
							state_q <= S_RANGE;
						end
					end
				end
				S_RANGE: begin
					if (hi_q > lo_q) begin
						l_q     <= lo_q[AW-1:0];
						r_q     <= hi_q[AW-1:0];
						rmv_q   <= 1'b1;
						state_q <= S_PIV;
					end else if (sp_q != '0) begin
						lo_q <= stack_q[sp_m1[SIW-1:0]].lo;
						hi_q <= stack_q[sp_m1[SIW-1:0]].hi;
						sp_q <= sp_m1;
					end else begin
						k_q     <= '0;
						state_q <= S_EADDR;
					end
				end
				S_PIV: begin
					pv_q    <= $signed(ram_rdata);
					state_q <= S_CMP;
				end
				S_CMP: begin
					l_q   <= l_nx;
					r_q   <= r_nx;
					rmv_q <= rmv_nx;
					if (!(l_nx < r_nx)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					// Keep the smaller side, stack the larger one when it needs work.
					if (lsz > rsz) begin
						if (lsz > 0 && sp_q < SPW'(SD)) begin
							stack_q[sp_q[SIW-1:0]] <= '{lo: lo_q, hi: p_m1};
							sp_q <= sp_q + SPW'(1);
						end
						lo_q <= p_p1;
					end else begin
						if (rsz > 0 && sp_q < SPW'(SD)) begin
							stack_q[sp_q[SIW-1:0]] <= '{lo: p_p1, hi: hi_q};
							sp_q <= sp_q + SPW'(1);
						end
						hi_q <= p_m1;
					end
					state_q <= S_RANGE;
				end
				S_EADDR: begin
					state_q <= S_EDATA;
				end
				S_EDATA: begin
					if (out_free) begin
						sorted_value_q <= $signed(ram_rdata);
						final_res_q    <= is_final;
						if (is_final) begin
							count_q <= '0;
							state_q <= S_LOAD;
						end else begin
							k_q <= k_q + AW'(1);
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	assign item_stall   = (state_q != S_LOAD);
	assign res_valid    = res_valid_q;
	assign sorted_value = sorted_value_q;
	assign final_res    = final_res_q;

endmodule

### rtl/core/qse_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on qse_pkg for its default sizes.
`timescale 1ns / 1ps

module qse_ram #(
	parameter int WIDTH = qse_pkg::DATA_W,
	parameter int DEPTH = qse_pkg::DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
